// File: rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the pressure tank sequencer.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int unsigned LevelW  = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AIR_ON      = 3'd0,
    CFG_AIR_OFF     = 3'd1,
    CFG_ALARM_SET   = 3'd2,
    CFG_ALARM_CLEAR = 3'd3,
    CFG_READY       = 3'd4,
    CFG_RESTART     = 3'd5
  } cfg_idx_e;

  localparam logic [LevelW-1:0] AirOnRst      = 16'd1800;
  localparam logic [LevelW-1:0] AirOffRst     = 16'd2200;
  localparam logic [LevelW-1:0] AlarmSetRst   = 16'd3000;
  localparam logic [LevelW-1:0] AlarmClearRst = 16'd2500;
  localparam logic [LevelW-1:0] ReadyRst      = 16'd2000;
  localparam logic [TimeW-1:0]  RestartRst    = 32'd5000;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PRESS = 2'd1,
    MODE_RUN   = 2'd2
  } mode_e;

  typedef struct packed {
    logic [TimeW-1:0]  time_ms;
    logic              start_on;
    logic              level_high;
    logic              press_avail;
    logic              press_good;
    logic              pressure_overrange;
    logic [LevelW-1:0] pressure_level;
  } pts_in_t;

  typedef struct packed {
    logic       pump_on;
    logic       air_on;
    logic       drain_on;
    logic       siren_on;
    logic [1:0] mode_out;
  } pts_out_t;

  typedef struct packed {
    logic [LevelW-1:0] air_on_level;
    logic [LevelW-1:0] air_off_level;
    logic [LevelW-1:0] alarm_set_level;
    logic [LevelW-1:0] alarm_clear_level;
    logic [LevelW-1:0] ready_level;
    logic [TimeW-1:0]  restart_delay;
  } pts_cfg_t;

endpackage

// File: rtl/core/pts_cfg_regs.sv
// ----------------------------------------------------------------------------
// pts_cfg_regs
// Configuration register file: thresholds and restart delay, write only.
// ----------------------------------------------------------------------------
module pts_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pts_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [pts_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output pts_pkg::pts_cfg_t                cfg_o
);
  import pts_pkg::*;

  pts_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_AIR_ON:      cfg_d.air_on_level      = cfg_wdata_i[LevelW-1:0];
        CFG_AIR_OFF:     cfg_d.air_off_level     = cfg_wdata_i[LevelW-1:0];
        CFG_ALARM_SET:   cfg_d.alarm_set_level   = cfg_wdata_i[LevelW-1:0];
        CFG_ALARM_CLEAR: cfg_d.alarm_clear_level = cfg_wdata_i[LevelW-1:0];
        CFG_READY:       cfg_d.ready_level       = cfg_wdata_i[LevelW-1:0];
        CFG_RESTART:     cfg_d.restart_delay     = cfg_wdata_i[TimeW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.air_on_level      <= AirOnRst;
      cfg_q.air_off_level     <= AirOffRst;
      cfg_q.alarm_set_level   <= AlarmSetRst;
      cfg_q.alarm_clear_level <= AlarmClearRst;
      cfg_q.ready_level       <= ReadyRst;
      cfg_q.restart_delay     <= RestartRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/pts_core.sv
// ----------------------------------------------------------------------------
// pts_core
// Controller state and the one-tick update: alarm, pump timer, mode, air.
// ----------------------------------------------------------------------------
module pts_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  pts_pkg::pts_in_t  item_i,
  input  pts_pkg::pts_cfg_t cfg_i,
  output pts_pkg::pts_out_t result_o
);
  import pts_pkg::*;

  mode_e             mode_q, mode_d;
  logic              air_q, air_d;
  logic              pump_q, pump_d;
  logic              pend_q, pend_d;
  logic [TimeW-1:0]  stime_q, stime_d;
  logic              alarm_q, alarm_d;

  logic              usable;
  logic [TimeW-1:0]  elapsed;

  assign usable  = item_i.press_avail & item_i.press_good;
  // wrapping difference handles timestamp rollover
  assign elapsed = item_i.time_ms - stime_q;

  always_comb begin
    mode_d   = mode_q;
    air_d    = air_q;
    pump_d   = pump_q;
    pend_d   = pend_q;
    stime_d  = stime_q;
    alarm_d  = alarm_q;
    result_o = '0;

    if (item_i.pressure_overrange) begin
      alarm_d = 1'b1;
    end else if (usable) begin
      if (!alarm_q) begin
        if (item_i.pressure_level >= cfg_i.alarm_set_level) alarm_d = 1'b1;
      end else begin
        if (item_i.pressure_level <= cfg_i.alarm_clear_level) alarm_d = 1'b0;
      end
    end

    if (!item_i.start_on) begin
      mode_d  = MODE_IDLE;
      air_d   = 1'b0;
      pump_d  = 1'b0;
      pend_d  = 1'b0;
      stime_d = '0;
    end else begin
      if (item_i.level_high) begin
        pump_d = 1'b0;
        pend_d = 1'b0;
      end else if (!pump_q) begin
        if (!pend_q) begin
          pend_d  = 1'b1;
          stime_d = item_i.time_ms;
        end else if (elapsed >= cfg_i.restart_delay) begin
          pump_d = 1'b1;
          pend_d = 1'b0;
        end
      end

      if (mode_q == MODE_IDLE) begin
        mode_d = MODE_PRESS;
        air_d  = 1'b0;
      end

      if (item_i.press_avail && !usable) begin
        air_d = 1'b0;
      end else if (usable) begin
        if (item_i.pressure_level <= cfg_i.air_on_level) air_d = 1'b1;
        else if (item_i.pressure_level >= cfg_i.air_off_level) air_d = 1'b0;
        if (alarm_d) air_d = 1'b0;
        if (mode_d == MODE_PRESS && item_i.pressure_level >= cfg_i.ready_level) begin
          mode_d = MODE_RUN;
        end
      end

      result_o.pump_on  = pump_d;
      result_o.air_on   = usable & air_d & ~alarm_d;
      result_o.drain_on = (mode_d == MODE_RUN);
    end

    result_o.siren_on = alarm_d;
    result_o.mode_out = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      air_q   <= 1'b0;
      pump_q  <= 1'b0;
      pend_q  <= 1'b0;
      stime_q <= '0;
      alarm_q <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      air_q   <= air_d;
      pump_q  <= pump_d;
      pend_q  <= pend_d;
      stime_q <= stime_d;
      alarm_q <= alarm_d;
    end
  end

endmodule

// File: rtl/core/pressure_tank_sequencer.sv
// ----------------------------------------------------------------------------
// pressure_tank_sequencer
// Tank controller: one tick in, one set of relay drives and mode out.
// ----------------------------------------------------------------------------
// usage:
//   in channel: in_valid_i / in_stall_o / in_data_i, one tick per transaction.
//   out channel: out_valid_o / out_stall_i / out_data_o, one result for each
//   tick, in tick order.
//   config: cfg_we_i writes cfg_wdata_i to register cfg_index_i (0 air on,
//   1 air off, 2 alarm set, 3 alarm clear, 4 ready level, 5 restart delay);
//   write only while no transaction is in flight.
//   path: an accepted input goes to the input register, then the result
//   register, from which it is valid on out_valid_o; throughput is one tick per
//   cycle while the output is not stalled, set by the single combinational
//   update between the two registers.
//   reset: mode idle, all requests and the alarm cleared, config registers at
//   their default thresholds and restart delay; both pipeline stages empty.
//   stall: a stalled result holds; the input register, if empty, still takes one
//   more transaction, after which in_stall_o rises until the result drains.
// ----------------------------------------------------------------------------
module pressure_tank_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  pts_pkg::pts_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pts_pkg::pts_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [pts_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pts_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import pts_pkg::*;

  pts_cfg_t cfg;
  pts_in_t  item_q;
  logic     item_vld_q;
  pts_out_t res_q, res_d;
  logic     res_vld_q;
  logic     res_free;
  logic     step;
  logic     in_fire;

  assign res_free   = ~res_vld_q | ~out_stall_i;
  assign step       = item_vld_q & res_free;
  assign in_stall_o = item_vld_q & ~res_free;
  assign in_fire    = in_valid_i & ~in_stall_o;

  pts_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pts_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_fire) item_vld_q <= 1'b1;
      else if (step) item_vld_q <= 1'b0;
      if (step) res_vld_q <= 1'b1;
      else if (!out_stall_i) res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) item_q <= in_data_i;
    if (step) res_q <= res_d;
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule
